[design/flsl_pkg.sv]
`timescale 1ns / 1ps
package flsl_pkg;

   localparam int FFT_SIZE    = 128;
   localparam int SAMPLE_BITS = 16;
   localparam int HALF_SIZE   = FFT_SIZE / 2;
   localparam int LOG_N       = $clog2(FFT_SIZE);
   localparam int HALF_W      = LOG_N - 1;
   localparam int TW_SHIFT    = 7 - LOG_N;

   // Accumulator: sample times Q1.15 twiddle, summed over the block
   localparam int ACC_W = SAMPLE_BITS + 17 + LOG_N;
   localparam int RE_W  = ACC_W - 15;
   localparam int PWR_W = 2 * RE_W;
   localparam int EXP_W = $clog2(PWR_W);
   localparam int LG_W  = EXP_W + 16;
   localparam int D2_W  = LG_W + 2;
   localparam int MAG_W = LG_W + 1;
   localparam int MDB_W = MAG_W + 16;
   localparam int LO_W  = (MDB_W + 1) / 2;
   localparam int HI_W  = MDB_W - LO_W;
   localparam int TSUM_W = MDB_W + 20;
   localparam int T_W    = TSUM_W - 30;

   localparam int OFFSET_Q16 = (2 * (SAMPLE_BITS - 1) - 16) * 65536;
   localparam logic [TSUM_W-1:0] ROUND_BIAS = TSUM_W'(64'd15 << 29);
   localparam logic [18:0] LOG10_2_Q20 = 19'd315653;
   localparam logic [20:0] RECIP15     = 21'd1118482;
   localparam logic [T_W-1:0] T_CLAMP  = T_W'(983040);

   localparam logic [15:0] FFT_SCALE_RST = 16'd2048;
   localparam logic [15:0] DB_SCALE_RST  = 16'd5120;

   localparam logic CSR_FFT_SCALE = 1'b0;
   localparam logic CSR_DB_SCALE  = 1'b1;

   typedef enum logic [4:0] {
      ST_FILL, ST_LS_GO, ST_LS_WAIT, ST_MAC, ST_DRAIN, ST_WR,
      ST_RD, ST_PWR, ST_PSUM, ST_LGO, ST_LG_WAIT,
      ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_OUT
   } seq_state_type;

   typedef enum logic [2:0] {
      L_IDLE, L_NORM, L_SQ, L_ADJ, L_DONE
   } log_state_type;

   typedef struct packed {
      logic            done;
      logic [LG_W-1:0] lg;
   } log_stat_type;

   localparam logic [15:0] QSINE [0:32] = '{
      16'd0,     16'd1608,  16'd3212,  16'd4808,  16'd6393,  16'd7962,  16'd9512,
      16'd11039, 16'd12540, 16'd14010, 16'd15447, 16'd16846, 16'd18205, 16'd19520,
      16'd20788, 16'd22006, 16'd23170, 16'd24279, 16'd25330, 16'd26320, 16'd27246,
      16'd28106, 16'd28899, 16'd29622, 16'd30274, 16'd30853, 16'd31357, 16'd31786,
      16'd32138, 16'd32413, 16'd32610, 16'd32729, 16'd32768
   };

   // Sine over a full turn of 128 steps, Q1.15
   function automatic logic signed [16:0] sine128(input logic [6:0] t);
      logic [6:0] i;
      logic       neg;
      if (t <= 7'd32) begin
         i = t;
         neg = 1'b0;
      end else if (t <= 7'd64) begin
         i = 7'd64 - t;
         neg = 1'b0;
      end else if (t <= 7'd96) begin
         i = t - 7'd64;
         neg = 1'b1;
      end else begin
         i = 7'(8'd128 - {1'b0, t});
         neg = 1'b1;
      end
      sine128 = neg ? -$signed({1'b0, QSINE[i[5:0]]}) : $signed({1'b0, QSINE[i[5:0]]});
   endfunction

endpackage

[design/flsl_ram.sv]
`timescale 1ns / 1ps
module flsl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[design/flsl_log2.sv]
`timescale 1ns / 1ps
module flsl_log2
   import flsl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [PWR_W-1:0] value,
   output log_stat_type     stat
);

   log_state_type    state_ff, state_in;
   logic [PWR_W-1:0] sh_ff, sh_in;
   logic [EXP_W-1:0] e_ff, e_in;
   logic [30:0]      y_ff, y_in;
   logic [61:0]      sq_ff, sq_in;
   logic [15:0]      frac_ff, frac_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [31:0]      yn;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         state_ff <= state_in;
      end
      sh_ff   <= sh_in;
      e_ff    <= e_in;
      y_ff    <= y_in;
      sq_ff   <= sq_in;
      frac_ff <= frac_in;
      cnt_ff  <= cnt_in;
   end

   always_comb begin
      state_in = state_ff;
      sh_in    = sh_ff;
      e_in     = e_ff;
      y_in     = y_ff;
      sq_in    = sq_ff;
      frac_in  = frac_ff;
      cnt_in   = cnt_ff;
      yn       = sq_ff[61:30];
      stat.done = 1'b0;
      stat.lg   = {e_ff, frac_ff};
      unique case (state_ff)
         L_IDLE: begin
            if (start) begin
               sh_in   = value;
               e_in    = EXP_W'(PWR_W - 1);
               frac_in = '0;
               cnt_in  = '0;
               state_in = L_NORM;
            end
         end
         L_NORM: begin
            // shift one bit a cycle until the leading one reaches the top or the exponent hits zero
            if (sh_ff[PWR_W-1] || e_ff == '0) begin
               y_in = sh_ff[PWR_W-1 -: 31];
               state_in = L_SQ;
            end else begin
               sh_in = {sh_ff[PWR_W-2:0], 1'b0};
               e_in  = e_ff - 1'b1;
            end
         end
         L_SQ: begin
            sq_in = y_ff * y_ff;
            state_in = L_ADJ;
         end
         L_ADJ: begin
            frac_in = {frac_ff[14:0], yn[31]};
            y_in = yn[31] ? yn[31:1] : yn[30:0];
            cnt_in = cnt_ff + 1'b1;
            state_in = (cnt_ff == 4'd15) ? L_DONE : L_SQ;
         end
         L_DONE: begin
            stat.done = 1'b1;
            state_in = L_IDLE;
         end
         default: state_in = L_IDLE;
      endcase
   end

endmodule

[design/fft_log_spectrum_levels.sv]
`timescale 1ns / 1ps
// Sample requests take one cycle each; busy stays low while a block fills.
// The last sample raises busy for the log2 of fft_scale, the DFT work (one MAC pair a
// cycle) and one level pass per bin, which skips the log for a zero bin and whose log
// needs one normalize shift per leading zero bit of the power; no samples enter while busy.
// Each bin level is shown for one cycle on rsp_valid; the receiver cannot stall.
// Reset (synchronous) empties the block and restores fft_scale and db_scale defaults.
module fft_log_spectrum_levels
   import flsl_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   output logic [5:0]                    rsp_bin_index,
   output logic [15:0]                   rsp_level,
   output logic                          rsp_last_bin,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [15:0]                   csr_wdata
);

   seq_state_type state_ff, state_in;

   logic [LOG_N-1:0]  fill_ff, fill_in;
   logic [HALF_W-1:0] k_ff, k_in;
   logic [LOG_N-1:0]  n_ff, n_in;
   logic [15:0]       fft_scale_ff, db_scale_ff;
   logic [LG_W-1:0]   ls_ff, ls_in;

   // DFT pipeline: address, operand, product, accumulate
   logic                          issue, acc_clear;
   logic                          v1_ff, v2_ff, v3_ff;
   logic [6:0]                    tw_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic signed [16:0]            cos_ff, sin_ff;
   logic signed [SAMPLE_BITS+16:0] pre_ff, pim_ff;
   logic signed [ACC_W-1:0]       acc_re_ff, acc_im_ff;

   // level path
   logic signed [PWR_W-1:0] sq_re_ff, sq_re_in, sq_im_ff, sq_im_in;
   logic [PWR_W-1:0]        p_ff, p_in;
   logic [D2_W-1:0]         d2_ff, d2_in;
   logic [MDB_W-1:0]        mdb_ff, mdb_in;
   logic [LO_W+18:0]        lo_ff, lo_in;
   logic [HI_W+18:0]        hi_ff, hi_in;
   logic [T_W-1:0]          t_ff, t_in;
   logic [40:0]             qp_ff, qp_in;
   logic [15:0]             level_ff, level_in;
   logic [TSUM_W-1:0]       tsum;
   logic [MAG_W-1:0]        mag;
   logic [16:0]             q;

   // memories
   logic                          sram_we, spec_we;
   logic [SAMPLE_BITS-1:0]        sram_rdata;
   logic [63:0]                   spec_wdata, spec_rdata;
   logic signed [RE_W-1:0]        rd_re, rd_im;

   logic                          log_start;
   logic [PWR_W-1:0]              log_value;
   log_stat_type                  log_stat;

   function automatic logic signed [RE_W-1:0] round15(input logic signed [ACC_W-1:0] a);
      logic [ACC_W-1:0] m;
      logic [ACC_W-1:0] r;
      m = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
      r = (m + ACC_W'(1 << 14)) >> 15;
      round15 = a[ACC_W-1] ? RE_W'(-r) : RE_W'(r);
   endfunction

   flsl_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(FFT_SIZE)) u_sample_ram (
      .clock (clock),
      .we    (sram_we),
      .waddr (fill_ff),
      .wdata (req_sample),
      .raddr (n_ff),
      .rdata (sram_rdata)
   );

   flsl_ram #(.WIDTH(64), .DEPTH(HALF_SIZE)) u_spectrum_ram (
      .clock (clock),
      .we    (spec_we),
      .waddr (k_ff),
      .wdata (spec_wdata),
      .raddr (k_ff),
      .rdata (spec_rdata)
   );

   flsl_log2 u_log2 (
      .clock (clock),
      .reset (reset),
      .start (log_start),
      .value (log_value),
      .stat  (log_stat)
   );

   assign spec_wdata = {32'(round15(acc_re_ff)), 32'(round15(acc_im_ff))};
   assign rd_re = spec_rdata[32 +: RE_W];
   assign rd_im = spec_rdata[0 +: RE_W];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fft_scale_ff <= FFT_SCALE_RST;
         db_scale_ff  <= DB_SCALE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FFT_SCALE: fft_scale_ff <= csr_wdata;
            CSR_DB_SCALE:  db_scale_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // DFT multiply-accumulate pipeline, one sample-twiddle pair a cycle while ST_MAC issues
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      tw_ff  <= 7'(LOG_N'(k_ff * n_ff)) << TW_SHIFT;
      x_ff   <= sram_rdata;
      cos_ff <= sine128(7'(tw_ff + 7'd32));
      sin_ff <= sine128(tw_ff);
      pre_ff <= x_ff * cos_ff;
      pim_ff <= x_ff * sin_ff;
      if (acc_clear) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (v3_ff) begin
         acc_re_ff <= acc_re_ff + ACC_W'(pre_ff);
         acc_im_ff <= acc_im_ff - ACC_W'(pim_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         fill_ff  <= '0;
         k_ff     <= '0;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         k_ff     <= k_in;
         n_ff     <= n_in;
      end
      ls_ff    <= ls_in;
      sq_re_ff <= sq_re_in;
      sq_im_ff <= sq_im_in;
      p_ff     <= p_in;
      d2_ff    <= d2_in;
      mdb_ff   <= mdb_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      t_ff     <= t_in;
      qp_ff    <= qp_in;
      level_ff <= level_in;
   end

   assign tsum = TSUM_W'(lo_ff) + (TSUM_W'(hi_ff) << LO_W) + ROUND_BIAS;
   assign mag  = MAG_W'(-d2_ff);
   assign q    = qp_ff[40:24];

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      k_in      = k_ff;
      n_in      = n_ff;
      ls_in     = ls_ff;
      sq_re_in  = sq_re_ff;
      sq_im_in  = sq_im_ff;
      p_in      = p_ff;
      d2_in     = d2_ff;
      mdb_in    = mdb_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      t_in      = t_ff;
      qp_in     = qp_ff;
      level_in  = level_ff;
      sram_we   = 1'b0;
      spec_we   = 1'b0;
      issue     = 1'b0;
      acc_clear = 1'b0;
      log_start = 1'b0;
      log_value = p_ff;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_FILL: begin
            // store the sample; the last one of a block starts the transform
            if (start) begin
               sram_we = 1'b1;
               fill_in = fill_ff + 1'b1;
               if (fill_ff == LOG_N'(FFT_SIZE - 1)) begin
                  fill_in  = '0;
                  state_in = ST_LS_GO;
               end
            end
         end
         ST_LS_GO: begin
            log_start = 1'b1;
            log_value = (fft_scale_ff == '0) ? PWR_W'(1) : PWR_W'(fft_scale_ff);
            state_in  = ST_LS_WAIT;
         end
         ST_LS_WAIT: begin
            if (log_stat.done) begin
               ls_in     = log_stat.lg;
               k_in      = '0;
               n_in      = '0;
               acc_clear = 1'b1;
               state_in  = ST_MAC;
            end
         end
         ST_MAC: begin
            issue = 1'b1;
            n_in  = n_ff + 1'b1;
            if (n_ff == LOG_N'(FFT_SIZE - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the last product to land in the accumulators
            if (!v1_ff && !v2_ff && !v3_ff) begin
               state_in = ST_WR;
            end
         end
         ST_WR: begin
            spec_we   = 1'b1;
            acc_clear = 1'b1;
            n_in      = '0;
            if (k_ff == HALF_W'(HALF_SIZE - 1)) begin
               k_in     = '0;
               state_in = ST_RD;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_MAC;
            end
         end
         ST_RD: begin
            state_in = ST_PWR;
         end
         ST_PWR: begin
            sq_re_in = rd_re * rd_re;
            sq_im_in = rd_im * rd_im;
            state_in = ST_PSUM;
         end
         ST_PSUM: begin
            p_in     = PWR_W'(sq_re_ff) + PWR_W'(sq_im_ff);
            state_in = ST_LGO;
         end
         ST_LGO: begin
            // zero power gives level zero without a log
            if (p_ff == '0) begin
               level_in = '0;
               state_in = ST_OUT;
            end else begin
               log_start = 1'b1;
               state_in  = ST_LG_WAIT;
            end
         end
         ST_LG_WAIT: begin
            if (log_stat.done) begin
               d2_in = D2_W'(log_stat.lg) - D2_W'({ls_ff, 1'b0}) - D2_W'(OFFSET_Q16);
               state_in = ST_M1;
            end
         end
         ST_M1: begin
            // at or above 0 dB, or no dB scaling: full level
            if (!d2_ff[D2_W-1] || db_scale_ff == '0) begin
               level_in = 16'hFFFF;
               state_in = ST_OUT;
            end else begin
               mdb_in   = mag * db_scale_ff;
               state_in = ST_M2;
            end
         end
         ST_M2: begin
            lo_in    = mdb_ff[LO_W-1:0] * LOG10_2_Q20;
            state_in = ST_M3;
         end
         ST_M3: begin
            hi_in    = mdb_ff[MDB_W-1:LO_W] * LOG10_2_Q20;
            state_in = ST_M4;
         end
         ST_M4: begin
            t_in     = tsum[TSUM_W-1:30];
            state_in = ST_M5;
         end
         ST_M5: begin
            // quotient of 65536 or more clamps to level zero
            if (t_ff >= T_CLAMP) begin
               level_in = '0;
               state_in = ST_OUT;
            end else begin
               qp_in    = t_ff[19:0] * RECIP15;
               state_in = ST_M6;
            end
         end
         ST_M6: begin
            level_in = (q == '0) ? 16'hFFFF : 16'(17'd65536 - q);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (k_ff == HALF_W'(HALF_SIZE - 1)) begin
               k_in     = '0;
               state_in = ST_FILL;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_RD;
            end
         end
         default: state_in = ST_FILL;
      endcase
   end

   assign busy          = (state_ff != ST_FILL);
   assign rsp_bin_index = 6'(k_ff);
   assign rsp_level     = level_ff;
   assign rsp_last_bin  = (k_ff == HALF_W'(HALF_SIZE - 1));

   // the final bin returns the block to sample collection
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_bin |=> !busy)
      else $error("block did not return to fill after last bin");

   // the sample completing a block starts the transform
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && fill_ff == LOG_N'(FFT_SIZE - 1) |=> busy)
      else $error("full block did not start the transform");

   // a level strobe never repeats in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back level strobe");

   // the log unit only finishes while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      log_stat.done |-> (state_ff == ST_LS_WAIT || state_ff == ST_LG_WAIT))
      else $error("log result arrived outside a wait state");

   // accumulation never overlaps the spectrum write
   assert property (@(posedge clock) disable iff (reset)
      spec_we |-> !v3_ff && !issue)
      else $error("spectrum written while products in flight");

endmodule

[tb/fft_log_spectrum_levels_tb.sv]
`timescale 1ns / 1ps
module fft_log_spectrum_levels_tb;
   import flsl_pkg::*;

   localparam longint LEVEL_DIVISOR = 64'd16106127360;
   localparam int     CYCLE_LIMIT   = 2000000;

   typedef struct {
      logic [5:0]  bin_index;
      logic [15:0] level;
      logic        last_bin;
   } bin_level_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic                          rsp_valid;
   logic [5:0]                    rsp_bin_index;
   logic [15:0]                   rsp_level;
   logic                          rsp_last_bin;
   logic                          csr_we = 1'b0;
   logic                          csr_index = CSR_FFT_SCALE;
   logic [15:0]                   csr_wdata = '0;

   // Predictor state: samples of the block being filled and a shadow of the CSRs
   int            block_samples [FFT_SIZE];
   int            fill_count;
   logic [15:0]   fft_scale_shadow;
   logic [15:0]   db_scale_shadow;
   // Ring of predicted levels: the predictor advances the write count, the checker the read count
   bin_level_type expected_levels [FFT_SIZE];
   int            exp_wr_count = 0;
   int            exp_rd_count = 0;
   int            mismatches = 0;
   int            cycles = 0;

   fft_log_spectrum_levels dut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Sine over a full turn of 128 steps, Q1.15, from the quarter table
   function automatic longint turn_sine(input int t);
      int u;
      u = t & 127;
      if (u <= 32) return QSINE[u];
      if (u <= 64) return QSINE[64 - u];
      if (u <= 96) return -longint'(QSINE[u - 64]);
      return -longint'(QSINE[128 - u]);
   endfunction

   // Round to nearest, ties away from zero
   function automatic longint shift_round15(input longint a);
      longint m;
      m = (a < 0) ? -a : a;
      m = (m + (64'sd1 <<< 14)) >>> 15;
      return (a < 0) ? -m : m;
   endfunction

   // log2 in Q.16 by normalizing to Q1.30 and repeated squaring
   function automatic longint log2_fixed(input logic [63:0] v);
      int          e;
      logic [63:0] y;
      longint      frac;
      e = 63;
      frac = 0;
      while (e > 0 && v[e] == 1'b0) e--;
      y = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
      for (int i = 0; i < 16; i++) begin
         y = (y * y) >> 30;
         frac = frac << 1;
         if (y >= (64'd1 << 31)) begin
            frac = frac | 1;
            y = y >> 1;
         end
      end
      return longint'(e) * 65536 + frac;
   endfunction

   // DFT of the filled block, then log-magnitude level of each lower bin
   task automatic predict_spectrum_levels();
      longint        acc_re, acc_im, re, im, ls, d2, num, lv, m;
      logic [63:0]   pwr;
      bin_level_type item;
      ls = log2_fixed((fft_scale_shadow == 0) ? 64'd1 : 64'(fft_scale_shadow));
      for (int k = 0; k < HALF_SIZE; k++) begin
         acc_re = 0;
         acc_im = 0;
         for (int n = 0; n < FFT_SIZE; n++) begin
            acc_re += longint'(block_samples[n]) * turn_sine(((k * n) & 127) + 32);
            acc_im -= longint'(block_samples[n]) * turn_sine((k * n) & 127);
         end
         re = shift_round15(acc_re);
         im = shift_round15(acc_im);
         pwr = 64'(re * re) + 64'(im * im);
         lv = 0;
         if (pwr != 0) begin
            d2 = log2_fixed(pwr) - 30 * 65536 - 2 * ls + 16 * 65536;
            num = d2 * longint'(db_scale_shadow) * 315653;
            m = (num < 0) ? -num : num;
            m = (m + LEVEL_DIVISOR / 2) / LEVEL_DIVISOR;
            lv = 65536 + ((num < 0) ? -m : m);
            if (lv < 0) lv = 0;
            if (lv > 65535) lv = 65535;
         end
         item.bin_index = 6'(k);
         item.level = 16'(lv);
         item.last_bin = (k == HALF_SIZE - 1);
         expected_levels[exp_wr_count % FFT_SIZE] = item;
         exp_wr_count++;
      end
   endtask

   // Send one sample request; hold start across back-to-back requests
   task automatic send_sample(input logic signed [15:0] value);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (busy);
      block_samples[fill_count] = value;
      fill_count++;
      if (fill_count == FFT_SIZE) begin
         fill_count = 0;
         predict_spectrum_levels();
      end
   endtask

   // Drop start and let every pending bin level come out
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (exp_rd_count != exp_wr_count) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] value);
      start <= 1'b0;
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FFT_SCALE) fft_scale_shadow = value;
      else db_scale_shadow = value;
   endtask

   // Sample source: 0 full-scale noise, 1 small noise, 2 tone plus noise
   function automatic logic signed [15:0] make_sample(input int mode, input int n,
                                                       input int bin, input int amp);
      if (mode == 0) return 16'($urandom);
      if (mode == 1) return 16'($signed($urandom_range(0, 64)) - 32);
      return 16'((longint'(amp) * turn_sine(n * bin)) / 32768 +
                 $signed($urandom_range(0, 8)) - 4);
   endfunction

   // Send at least one sample, then fill up to the end of the block
   task automatic send_block_rest(input int mode);
      int bin, amp;
      bin = $urandom_range(0, 63);
      amp = $urandom_range(1, 32767);
      do begin
         send_sample(make_sample(mode, fill_count, bin, amp));
      end while (fill_count != 0);
   endtask

   // Field extremes and alternating bit patterns at the head of a default block
   task automatic test_extremes();
      logic signed [15:0] heads [10] = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1,
         16'sd1, 16'sh5555, 16'shAAAA, 16'sh00FF, 16'shFF00, 16'sh7FFF};
      foreach (heads[i]) send_sample(heads[i]);
      send_block_rest(0);
      drain();
   endtask

   // All-zero block at the most sensitive settings: every bin reads level 0
   task automatic test_zero_power();
      write_csr(CSR_FFT_SCALE, 16'd1);
      write_csr(CSR_DB_SCALE, 16'hFFFF);
      repeat (FFT_SIZE) send_sample(16'sd0);
      drain();
   endtask

   // Least sensitive settings: largest divisor and no dB scaling
   task automatic test_scale_extremes();
      write_csr(CSR_FFT_SCALE, 16'hFFFF);
      write_csr(CSR_DB_SCALE, 16'd0);
      send_sample(16'sh8000);
      send_block_rest(0);
      drain();
   endtask

   // Rewrite both CSRs mid-block; zero fft_scale acts as the smallest divisor
   task automatic test_mid_block_write();
      write_csr(CSR_FFT_SCALE, 16'($urandom_range(1, 65535)));
      write_csr(CSR_DB_SCALE, 16'd256);
      repeat (60) send_sample(make_sample(1, 0, 0, 0));
      write_csr(CSR_FFT_SCALE, 16'd0);
      write_csr(CSR_DB_SCALE, 16'($urandom_range(1, 65535)));
      send_sample(16'sh7FFF);
      send_block_rest(2);
      drain();
   endtask

   // Compare each bin level against the oldest prediction
   always @(posedge clock) begin
      bin_level_type exp_item;
      if (!reset && rsp_valid) begin
         if (exp_rd_count == exp_wr_count) begin
            $error("unexpected result: bin_index %0d level %0d", rsp_bin_index, rsp_level);
            mismatches++;
         end else begin
            exp_item = expected_levels[exp_rd_count % FFT_SIZE];
            exp_rd_count++;
            if (rsp_bin_index !== exp_item.bin_index) begin
               $error("bin_index: expected %0d actual %0d", exp_item.bin_index, rsp_bin_index);
               mismatches++;
            end
            if (rsp_level !== exp_item.level) begin
               $error("level: expected %0d actual %0d", exp_item.level, rsp_level);
               mismatches++;
            end
            if (rsp_last_bin !== exp_item.last_bin) begin
               $error("last_bin: expected %0d actual %0d", exp_item.last_bin, rsp_last_bin);
               mismatches++;
            end
         end
      end
   end

   initial begin
      fill_count = 0;
      fft_scale_shadow = FFT_SCALE_RST;
      db_scale_shadow = DB_SCALE_RST;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_zero_power();
      test_scale_extremes();
      test_mid_block_write();
      if (mismatches == 0 && exp_rd_count == exp_wr_count) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[sim.f]
design/flsl_pkg.sv
design/flsl_ram.sv
design/flsl_log2.sv
design/fft_log_spectrum_levels.sv
tb/fft_log_spectrum_levels_tb.sv
